// ===== src/beg_pkg.sv =====
// Shared constants, register codes and types of the battery gauge.
package beg_pkg;

    localparam int MV_BITS       = 16;
    localparam int TIME_BITS     = 32;
    localparam int PERIOD_BITS   = 20;
    localparam int WINDOW_BITS   = 24;
    localparam int SHIFT_BITS    = 4;
    localparam int DELTA_BITS    = 16;
    localparam int PCT_BITS      = 7;
    localparam int MIN_BITS      = 31;
    localparam int WMIN_BITS     = 17;
    localparam int PCT_NUM_BITS  = MV_BITS + PCT_BITS;
    localparam int PROD_BITS     = MV_BITS + WMIN_BITS;
    localparam int DIVD_BITS     = (PROD_BITS > TIME_BITS) ? PROD_BITS : TIME_BITS;
    localparam int DIVR_BITS     = 16;
    localparam int DIV_CNT_BITS  = $clog2(DIVD_BITS);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam int MS_PER_MIN    = 60000;
    localparam int FULL_PERCENT  = 100;
    localparam int DELTA_MAX     = 32767;
    localparam int DELTA_MIN     = -32768;

    localparam logic [MIN_BITS-1:0] MINUTES_MAX = {MIN_BITS{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_MV    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_MV    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_MS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_MS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_AVG_SHIFT = 3'd4;

    localparam logic [MV_BITS-1:0]     RST_MIN_MV    = MV_BITS'(3000);
    localparam logic [MV_BITS-1:0]     RST_MAX_MV    = MV_BITS'(4200);
    localparam logic [PERIOD_BITS-1:0] RST_PERIOD_MS = PERIOD_BITS'(1000);
    localparam logic [WINDOW_BITS-1:0] RST_WINDOW_MS = WINDOW_BITS'(600000);
    localparam logic [SHIFT_BITS-1:0]  RST_AVG_SHIFT = SHIFT_BITS'(3);

    typedef struct packed {
        logic [MV_BITS-1:0]     min_mv;
        logic [MV_BITS-1:0]     max_mv;
        logic [PERIOD_BITS-1:0] period_ms;
        logic [WINDOW_BITS-1:0] window_ms;
        logic [SHIFT_BITS-1:0]  avg_shift;
    } t_cfg;

    typedef struct packed {
        logic upd;
        logic trend;
    } t_trk_ctl;

    typedef struct packed {
        logic                   seeded;
        logic [MV_BITS-1:0]     avg_mv;
        logic                   trend_ready;
        logic [DELTA_BITS-1:0]  delta_mv;
        logic [TIME_BITS-1:0]   span_ms;
        logic                   taken;
    } t_trk_st;

endpackage

// ===== src/beg_ifs.sv =====
// Valid/ready channel interfaces: samples in, gauge results out, register writes.
interface beg_in_if import beg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] time_ms;
    logic [MV_BITS-1:0]   sample_mv;

    modport source (output valid, output time_ms, output sample_mv, input ready);
    modport sink   (input valid, input time_ms, input sample_mv, output ready);
endinterface

interface beg_out_if import beg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                percent_valid;
    logic [PCT_BITS-1:0] charge_percent;
    logic                runtime_valid;
    logic [MIN_BITS-1:0] minutes_left;
    logic                sample_taken;

    modport source (output valid, output percent_valid, output charge_percent,
                    output runtime_valid, output minutes_left, output sample_taken,
                    input ready);
    modport sink   (input valid, input percent_valid, input charge_percent,
                    input runtime_valid, input minutes_left, input sample_taken,
                    output ready);
endinterface

interface beg_cfg_if import beg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  reg_index;
    logic [CFG_DATA_BITS-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== src/battery_ema_gauge_core.sv =====
// Top level of the battery gauge: sequencer, result assembly and output register.
//
// Feed one beat per sample on i_in: a wrapping millisecond time and a voltage
// in millivolts. Each input beat gives exactly one beat on o_out carrying the
// charge percentage, the minutes to empty, their valid flags and whether the
// sample moved the average. Registers are written on i_cfg (index, data); the
// user must write them only while no item is in flight, which the block does
// not enforce; i_cfg.ready is always high, unknown indexes are dropped.
// Each item first updates the average and then the trend, then bit-serial
// dividers run twice in a row (percent and window minutes in parallel, then
// the minutes estimate); a new sample is accepted only after the last result is loaded.
// The output register holds a finished result until o_out.ready; meanwhile a
// new sample is already accepted and processed, and that one waits in its last
// step until the output register is free.
// Reset (synchronous, active low) restores the default registers and clears
// the average and trend, so the next nonzero sample seeds the gauge again.
module battery_ema_gauge_core import beg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    beg_in_if.sink    i_in,
    beg_out_if.source o_out,
    beg_cfg_if.sink   i_cfg
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UPD   = 3'd1;
    localparam logic [2:0] S_TREND = 3'd2;
    localparam logic [2:0] S_DIVA  = 3'd3;
    localparam logic [2:0] S_WAITA = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_WAITB = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    t_cfg     w_cfg;
    t_trk_ctl w_ctl;
    t_trk_st  w_st;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [TIME_BITS-1:0] r_time_ms;
    logic [MV_BITS-1:0]   r_sample_mv;

    logic                 r_pvalid;
    logic                 r_rvalid;
    logic                 r_pos;
    logic [MV_BITS-1:0]   r_head;
    logic [DIVR_BITS-1:0] r_drop;

    logic                 r_out_valid;
    logic                 r_out_pvalid;
    logic [PCT_BITS-1:0]  r_out_pct;
    logic                 r_out_rvalid;
    logic [MIN_BITS-1:0]  r_out_mins;
    logic                 r_out_taken;

    logic                    w_accept;
    logic                    w_load;
    logic                    w_pos;
    logic [MV_BITS-1:0]      w_head;
    logic [PCT_NUM_BITS-1:0] w_pct_num;
    logic                    w_start_a;
    logic                    w_start_b;
    logic [DIVD_BITS-1:0]    w_dividend_b;
    logic [DIVR_BITS-1:0]    w_divisor_b;
    logic                    w_busy_a;
    logic                    w_busy_b;
    logic [DIVD_BITS-1:0]    w_quo_a;
    logic [DIVD_BITS-1:0]    w_quo_b;
    logic [WMIN_BITS-1:0]    w_wmin;
    logic [PCT_BITS-1:0]     w_pct;
    logic [MIN_BITS-1:0]     w_mins;

    beg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign w_ctl.upd   = (r_state == S_UPD);
    assign w_ctl.trend = (r_state == S_TREND);

    beg_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_time_ms   (r_time_ms),
        .i_sample_mv (r_sample_mv),
        .i_cfg       (w_cfg),
        .o_st        (w_st)
    );

    // percent numerator and headroom above empty
    assign w_pos     = (w_st.avg_mv > w_cfg.min_mv);
    assign w_head    = w_pos ? (w_st.avg_mv - w_cfg.min_mv) : '0;
    assign w_pct_num = PCT_NUM_BITS'(w_head) * PCT_NUM_BITS'(FULL_PERCENT);

    assign w_start_a = (r_state == S_DIVA);
    assign w_start_b = (r_state == S_DIVA) || (r_state == S_MUL);

    // window minutes below one count as one
    assign w_wmin = (w_quo_b == '0) ? WMIN_BITS'(1) : w_quo_b[WMIN_BITS-1:0];

    // divider B: first span / one minute, then headroom * minutes / drop
    always_comb begin
        if (r_state == S_DIVA) begin
            w_dividend_b = DIVD_BITS'(w_st.span_ms);
            w_divisor_b  = DIVR_BITS'(MS_PER_MIN);
        end else begin
            w_dividend_b = DIVD_BITS'(r_head) * DIVD_BITS'(w_wmin);
            w_divisor_b  = r_drop;
        end
    end

    beg_div u_div_pct (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start_a),
        .i_dividend (DIVD_BITS'(w_pct_num)),
        .i_divisor  (DIVR_BITS'(w_cfg.max_mv - w_cfg.min_mv)),
        .o_busy     (w_busy_a),
        .o_quotient (w_quo_a)
    );

    beg_div u_div_run (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start_b),
        .i_dividend (w_dividend_b),
        .i_divisor  (w_divisor_b),
        .o_busy     (w_busy_b),
        .o_quotient (w_quo_b)
    );

    assign w_pct  = (w_quo_a > DIVD_BITS'(FULL_PERCENT)) ? PCT_BITS'(FULL_PERCENT)
                                                         : w_quo_a[PCT_BITS-1:0];
    assign w_mins = (w_quo_b[DIVD_BITS-1:MIN_BITS] != '0) ? MINUTES_MAX
                                                          : w_quo_b[MIN_BITS-1:0];

    assign w_accept = i_in.valid && i_in.ready;
    assign w_load   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_UPD;
            S_UPD:   n_state = S_TREND;
            S_TREND: n_state = S_DIVA;
            S_DIVA:  n_state = S_WAITA;
            S_WAITA: if (!w_busy_a && !w_busy_b) n_state = S_MUL;
            S_MUL:   n_state = S_WAITB;
            S_WAITB: if (!w_busy_b) n_state = S_DONE;
            S_DONE:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_time_ms   <= i_in.time_ms;
            r_sample_mv <= i_in.sample_mv;
        end
        if (r_state == S_DIVA) begin
            r_pvalid <= w_st.seeded && (w_cfg.max_mv > w_cfg.min_mv);
            r_rvalid <= w_st.trend_ready && (w_st.span_ms != '0)
                        && w_st.delta_mv[DELTA_BITS-1];
            r_pos    <= w_pos;
            r_head   <= w_head;
            r_drop   <= DIVR_BITS'(-w_st.delta_mv);
        end
        if (w_load) begin
            r_out_pvalid <= r_pvalid;
            r_out_pct    <= (r_pvalid && r_pos) ? w_pct : '0;
            r_out_rvalid <= r_rvalid;
            r_out_mins   <= (r_rvalid && r_pos) ? w_mins : '0;
            r_out_taken  <= w_st.taken;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.percent_valid  = r_out_pvalid;
    assign o_out.charge_percent = r_out_pct;
    assign o_out.runtime_valid  = r_out_rvalid;
    assign o_out.minutes_left   = r_out_mins;
    assign o_out.sample_taken   = r_out_taken;

endmodule

// ===== src/beg_regs.sv =====
// Configuration register file of the battery gauge.
module beg_regs import beg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    beg_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    logic [MV_BITS-1:0]     r_min_mv;
    logic [MV_BITS-1:0]     r_max_mv;
    logic [PERIOD_BITS-1:0] r_period_ms;
    logic [WINDOW_BITS-1:0] r_window_ms;
    logic [SHIFT_BITS-1:0]  r_avg_shift;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mv    <= RST_MIN_MV;
            r_max_mv    <= RST_MAX_MV;
            r_period_ms <= RST_PERIOD_MS;
            r_window_ms <= RST_WINDOW_MS;
            r_avg_shift <= RST_AVG_SHIFT;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                REG_MIN_MV:    r_min_mv    <= i_cfg.wdata[MV_BITS-1:0];
                REG_MAX_MV:    r_max_mv    <= i_cfg.wdata[MV_BITS-1:0];
                REG_PERIOD_MS: r_period_ms <= i_cfg.wdata[PERIOD_BITS-1:0];
                REG_WINDOW_MS: r_window_ms <= i_cfg.wdata[WINDOW_BITS-1:0];
                REG_AVG_SHIFT: r_avg_shift <= i_cfg.wdata[SHIFT_BITS-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign o_cfg.min_mv    = r_min_mv;
    assign o_cfg.max_mv    = r_max_mv;
    assign o_cfg.period_ms = r_period_ms;
    assign o_cfg.window_ms = r_window_ms;
    assign o_cfg.avg_shift = r_avg_shift;

endmodule

// ===== src/beg_track.sv =====
// Sample gating, moving average and trend anchor state of the battery gauge.
module beg_track import beg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_trk_ctl             i_ctl,
    input  logic [TIME_BITS-1:0] i_time_ms,
    input  logic [MV_BITS-1:0]   i_sample_mv,
    input  t_cfg                 i_cfg,
    output t_trk_st              o_st
);

    logic                  r_seeded;
    logic [MV_BITS-1:0]    r_avg_mv;
    logic [TIME_BITS-1:0]  r_next_due_ms;
    logic [TIME_BITS-1:0]  r_anchor_ms;
    logic [MV_BITS-1:0]    r_anchor_mv;
    logic                  r_trend_ready;
    logic [DELTA_BITS-1:0] r_delta_mv;
    logic [TIME_BITS-1:0]  r_span_ms;
    logic                  r_taken;
    logic                  r_moved;

    logic [TIME_BITS-1:0]    w_due_diff;
    logic [TIME_BITS-1:0]    w_next_due;
    logic signed [MV_BITS:0] w_diff;
    logic signed [MV_BITS:0] w_step;
    logic [MV_BITS-1:0]      w_avg_new;
    logic [TIME_BITS-1:0]    w_elapsed;
    logic signed [MV_BITS:0] w_dv;
    logic signed [31:0]      w_dv32;
    logic [DELTA_BITS-1:0]   w_dv_sat;

    assign w_due_diff = i_time_ms - r_next_due_ms;
    assign w_next_due = i_time_ms + TIME_BITS'(i_cfg.period_ms);

    // floor(diff / 2^shift) is an arithmetic shift
    assign w_diff    = $signed({1'b0, i_sample_mv}) - $signed({1'b0, r_avg_mv});
    assign w_step    = w_diff >>> i_cfg.avg_shift;
    assign w_avg_new = r_avg_mv + w_step[MV_BITS-1:0];

    assign w_elapsed = i_time_ms - r_anchor_ms;
    assign w_dv      = $signed({1'b0, r_avg_mv}) - $signed({1'b0, r_anchor_mv});
    assign w_dv32    = 32'(w_dv);

    always_comb begin
        if (w_dv32 > DELTA_MAX) begin
            w_dv_sat = DELTA_BITS'(DELTA_MAX);
        end else if (w_dv32 < DELTA_MIN) begin
            w_dv_sat = DELTA_BITS'(DELTA_MIN);
        end else begin
            w_dv_sat = w_dv32[DELTA_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded      <= 1'b0;
            r_avg_mv      <= '0;
            r_next_due_ms <= '0;
            r_anchor_ms   <= '0;
            r_anchor_mv   <= '0;
            r_trend_ready <= 1'b0;
            r_delta_mv    <= '0;
            r_span_ms     <= '0;
            r_taken       <= 1'b0;
            r_moved       <= 1'b0;
        end else if (i_ctl.upd) begin
            r_taken <= 1'b0;
            r_moved <= 1'b0;
            if (i_sample_mv != '0) begin
                if (!r_seeded) begin
                    r_seeded      <= 1'b1;
                    r_avg_mv      <= i_sample_mv;
                    r_anchor_ms   <= i_time_ms;
                    r_anchor_mv   <= i_sample_mv;
                    r_next_due_ms <= w_next_due;
                    r_taken       <= 1'b1;
                end else if (!w_due_diff[TIME_BITS-1]) begin
                    r_next_due_ms <= w_next_due;
                    r_avg_mv      <= w_avg_new;
                    r_taken       <= 1'b1;
                    r_moved       <= 1'b1;
                end
            end
        end else if (i_ctl.trend) begin
            // move the anchor once the window has elapsed, using the new average
            if (r_moved && (w_elapsed >= TIME_BITS'(i_cfg.window_ms))) begin
                r_delta_mv    <= w_dv_sat;
                r_span_ms     <= w_elapsed;
                r_trend_ready <= 1'b1;
                r_anchor_ms   <= i_time_ms;
                r_anchor_mv   <= r_avg_mv;
            end
        end
    end

    assign o_st.seeded      = r_seeded;
    assign o_st.avg_mv      = r_avg_mv;
    assign o_st.trend_ready = r_trend_ready;
    assign o_st.delta_mv    = r_delta_mv;
    assign o_st.span_ms     = r_span_ms;
    assign o_st.taken       = r_taken;

endmodule

// ===== src/beg_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module beg_div import beg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIVD_BITS-1:0] i_dividend,
    input  logic [DIVR_BITS-1:0] i_divisor,
    output logic                 o_busy,
    output logic [DIVD_BITS-1:0] o_quotient
);

    logic                    r_busy;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [DIVR_BITS-1:0]    r_rem;
    logic [DIVD_BITS-1:0]    r_quo;
    logic [DIVR_BITS-1:0]    r_divisor;

    logic [DIVR_BITS:0]   w_shifted;
    logic [DIVR_BITS+1:0] w_trial;
    logic                 w_fits;

    // shift the next dividend bit into the remainder and try a subtract
    assign w_shifted = {r_rem, r_quo[DIVD_BITS-1]};
    assign w_trial   = {1'b0, w_shifted} - {2'b00, r_divisor};
    assign w_fits    = !w_trial[DIVR_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_BITS'(DIVD_BITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_trial[DIVR_BITS-1:0] : w_shifted[DIVR_BITS-1:0];
            r_quo <= {r_quo[DIVD_BITS-2:0], w_fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule
